// ===== hdl/mid_pkg.sv =====
// Shared widths and register codes for the minimum image distance block.
package mid_pkg;

	localparam int unsigned POS_W  = 32;  // signed Q16.16 position
	localparam int unsigned LEN_W  = 31;  // unsigned Q15.16 box length
	localparam int unsigned DIFF_W = 33;  // position difference, signed
	localparam int unsigned WIDE_W = 35;  // room for 2d +/- L
	localparam int unsigned ABS_W  = 32;  // magnitude of corrected difference
	localparam int unsigned SQ_W   = 64;  // square of one axis
	localparam int unsigned SUM_W  = 66;  // sum of three squares, Q34.32
	localparam int unsigned ROOT_W = 33;  // distance, Q17.16
	localparam int unsigned REM_W  = 34;  // partial remainder of the root
	localparam int unsigned AXES   = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH_X = 2'd0,
		CFG_LENGTH_Y = 2'd1,
		CFG_LENGTH_Z = 2'd2
	} cfg_index_t;

endpackage

// ===== hdl/mid_pair_if.sv =====
// Input channel: one pair of positions per word.
interface mid_pair_if;
	logic                             valid;
	logic                             ready;
	logic signed [mid_pkg::POS_W-1:0] first_x;
	logic signed [mid_pkg::POS_W-1:0] first_y;
	logic signed [mid_pkg::POS_W-1:0] first_z;
	logic signed [mid_pkg::POS_W-1:0] second_x;
	logic signed [mid_pkg::POS_W-1:0] second_y;
	logic signed [mid_pkg::POS_W-1:0] second_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input  ready
	);
	modport sink (
		input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready
	);
endinterface

// ===== hdl/mid_dist_if.sv =====
// Output channel: one distance per word.
interface mid_dist_if;
	logic                          valid;
	logic                          ready;
	logic [mid_pkg::ROOT_W-1:0]    distance;

	modport source (
		output valid, distance,
		input  ready
	);
	modport sink (
		input  valid, distance,
		output ready
	);
endinterface

// ===== hdl/minimum_image_distance.sv =====
// Minimum image distance between two points in an orthorhombic periodic box.
//
//  channel   dir  handshake          payload
//  pair      in   valid / ready      first_x/y/z, second_x/y/z (s32 Q16.16)
//  result    out  valid / ready      distance (u33 Q17.16)
//  cfg       in   cfg_we             cfg_index (2b), cfg_data (31b)
//
// One word per cycle sustained while result.ready is high. Five front stages (diff,
// wrap, abs, square, sum) are followed by 33 root stages, one result bit each.
// Every stage has its own valid and a local ready, so bubbles are squeezed out
// and a stalled output holds only the stages behind it. arst_n clears valids and
// sets all box lengths to 1.0.
module minimum_image_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mid_pkg::LEN_W-1:0]           cfg_data,
	mid_pair_if.sink                            pair,
	mid_dist_if.source                          result
);

	localparam int unsigned NSQ = mid_pkg::ROOT_W;

	// box lengths
	logic [mid_pkg::LEN_W-1:0] len_q [mid_pkg::AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mid_pkg::AXES; i++) len_q[i] <= mid_pkg::LEN_RESET;
		end else if (cfg_we) begin
			unique case (mid_pkg::cfg_index_t'(cfg_index))
				mid_pkg::CFG_LENGTH_X: len_q[0] <= cfg_data;
				mid_pkg::CFG_LENGTH_Y: len_q[1] <= cfg_data;
				mid_pkg::CFG_LENGTH_Z: len_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and local readies
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic sq_vld_s [NSQ];
	logic sq_rdy   [NSQ];

	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s5 = !vld_s5 || sq_rdy[0];
	assign pair.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= pair.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: differences
	logic [mid_pkg::DIFF_W-1:0] d_s1 [mid_pkg::AXES];

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d_s1[0] <= {pair.first_x[31], pair.first_x} - {pair.second_x[31], pair.second_x};
			d_s1[1] <= {pair.first_y[31], pair.first_y} - {pair.second_y[31], pair.second_y};
			d_s1[2] <= {pair.first_z[31], pair.first_z} - {pair.second_z[31], pair.second_z};
		end
	end

	// stage 2: single-period wrap, half box compared as 2d against L
	logic [mid_pkg::WIDE_W-1:0] dw   [mid_pkg::AXES];
	logic [mid_pkg::WIDE_W-1:0] d2   [mid_pkg::AXES];
	logic [mid_pkg::WIDE_W-1:0] lw   [mid_pkg::AXES];
	logic [mid_pkg::WIDE_W-1:0] lo_t [mid_pkg::AXES];
	logic [mid_pkg::WIDE_W-1:0] hi_t [mid_pkg::AXES];
	logic [mid_pkg::WIDE_W-1:0] cw   [mid_pkg::AXES];
	logic [mid_pkg::DIFF_W-1:0] c_s2 [mid_pkg::AXES];

	always_comb begin
		for (int i = 0; i < mid_pkg::AXES; i++) begin
			dw[i]   = {{2{d_s1[i][mid_pkg::DIFF_W-1]}}, d_s1[i]};
			d2[i]   = {dw[i][mid_pkg::WIDE_W-2:0], 1'b0};
			lw[i]   = {4'b0, len_q[i]};
			lo_t[i] = d2[i] + lw[i];
			hi_t[i] = d2[i] - lw[i];
			if (lo_t[i][mid_pkg::WIDE_W-1])
				cw[i] = dw[i] + lw[i];
			else if (!hi_t[i][mid_pkg::WIDE_W-1] && (hi_t[i] != '0))
				cw[i] = dw[i] - lw[i];
			else
				cw[i] = dw[i];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int i = 0; i < mid_pkg::AXES; i++) c_s2[i] <= cw[i][mid_pkg::DIFF_W-1:0];
		end
	end

	// stage 3: magnitude, always below 2^32
	logic [mid_pkg::DIFF_W-1:0] neg_c [mid_pkg::AXES];
	logic [mid_pkg::ABS_W-1:0]  a_s3  [mid_pkg::AXES];

	always_comb begin
		for (int i = 0; i < mid_pkg::AXES; i++) neg_c[i] = '0 - c_s2[i];
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			for (int i = 0; i < mid_pkg::AXES; i++)
				a_s3[i] <= c_s2[i][mid_pkg::DIFF_W-1] ? neg_c[i][mid_pkg::ABS_W-1:0]
				                                      : c_s2[i][mid_pkg::ABS_W-1:0];
		end
	end

	// stage 4: squares
	logic [mid_pkg::SQ_W-1:0] sq_s4 [mid_pkg::AXES];

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			for (int i = 0; i < mid_pkg::AXES; i++)
				sq_s4[i] <= mid_pkg::SQ_W'(a_s3[i]) * mid_pkg::SQ_W'(a_s3[i]);
		end
	end

	// stage 5: sum of squares
	logic [mid_pkg::SUM_W-1:0] sum_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			sum_s5 <= {2'b0, sq_s4[0]} + {2'b0, sq_s4[1]} + {2'b0, sq_s4[2]};
		end
	end

	// root stages: restoring square root, two radicand bits in, one root bit out
	logic [mid_pkg::REM_W-1:0]  sq_rem_s  [NSQ];
	logic [mid_pkg::ROOT_W-1:0] sq_root_s [NSQ];
	logic [mid_pkg::SUM_W-1:0]  sq_rad_s  [NSQ];

	for (genvar j = 0; j < NSQ; j++) begin : g_root
		logic                       v_in;
		logic [mid_pkg::REM_W-1:0]  rem_in;
		logic [mid_pkg::ROOT_W-1:0] root_in;
		logic [mid_pkg::SUM_W-1:0]  rad_in;
		logic [mid_pkg::REM_W+1:0]  t;
		logic [mid_pkg::REM_W+1:0]  trial;
		logic [mid_pkg::REM_W+1:0]  diff;
		logic                       ge;

		if (j == 0) begin : g_first
			assign v_in    = vld_s5;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = sum_s5;
		end else begin : g_next
			assign v_in    = sq_vld_s[j-1];
			assign rem_in  = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign rad_in  = sq_rad_s[j-1];
		end

		if (j == NSQ - 1) begin : g_last
			assign sq_rdy[j] = !sq_vld_s[j] || result.ready;
		end else begin : g_mid
			assign sq_rdy[j] = !sq_vld_s[j] || sq_rdy[j+1];
		end

		assign t     = {rem_in, rad_in[mid_pkg::SUM_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff  = t - trial;
		assign ge    = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else if (sq_rdy[j]) begin
				sq_vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (sq_rdy[j]) begin
				// remainder never exceeds twice the root, so it fits REM_W bits
				sq_rem_s[j]  <= ge ? diff[mid_pkg::REM_W-1:0] : t[mid_pkg::REM_W-1:0];
				sq_root_s[j] <= {root_in[mid_pkg::ROOT_W-2:0], ge};
				sq_rad_s[j]  <= {rad_in[mid_pkg::SUM_W-3:0], 2'b00};
			end
		end
	end

	assign result.valid    = sq_vld_s[NSQ-1];
	assign result.distance = sq_root_s[NSQ-1];

endmodule

// ===== dv/minimum_image_distance_tb.sv =====
// Self-checking testbench for the minimum image distance block: random handshake gaps, box changes.
`timescale 1ns / 1ps

module minimum_image_distance_tb;

	localparam int LATENCY      = 38;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;
	localparam int RANDOM_ITEMS = 250;

	localparam logic [mid_pkg::CFG_IDX_W-1:0]    CFG_UNMAPPED = 2'd3;
	localparam logic [mid_pkg::LEN_W-1:0]        LEN_MAX      = {mid_pkg::LEN_W{1'b1}};
	localparam logic signed [mid_pkg::POS_W-1:0] POS_MIN      =
		{1'b1, {(mid_pkg::POS_W-1){1'b0}}};
	localparam logic signed [mid_pkg::POS_W-1:0] POS_MAX      =
		{1'b0, {(mid_pkg::POS_W-1){1'b1}}};

	typedef struct packed {
		logic signed [mid_pkg::POS_W-1:0] first_x;
		logic signed [mid_pkg::POS_W-1:0] first_y;
		logic signed [mid_pkg::POS_W-1:0] first_z;
		logic signed [mid_pkg::POS_W-1:0] second_x;
		logic signed [mid_pkg::POS_W-1:0] second_y;
		logic signed [mid_pkg::POS_W-1:0] second_z;
	} pair_t;

	class distance_scoreboard;
		logic [mid_pkg::LEN_W-1:0]  len_x;
		logic [mid_pkg::LEN_W-1:0]  len_y;
		logic [mid_pkg::LEN_W-1:0]  len_z;
		logic [mid_pkg::ROOT_W-1:0] pending_distances[$];
		int pairs_seen;
		int distances_checked;
		int mismatches;
		int wraps_up;
		int wraps_down;

		function new();
			len_x = mid_pkg::LEN_RESET;
			len_y = mid_pkg::LEN_RESET;
			len_z = mid_pkg::LEN_RESET;
		endfunction

		function void set_length(logic [mid_pkg::CFG_IDX_W-1:0] idx,
				logic [mid_pkg::LEN_W-1:0] value);
			case (idx)
			mid_pkg::CFG_LENGTH_X: len_x = value;
			mid_pkg::CFG_LENGTH_Y: len_y = value;
			mid_pkg::CFG_LENGTH_Z: len_z = value;
			default: ;
			endcase
		endfunction

		// one period of correction; 2d against L keeps the half box exact
		function logic [mid_pkg::ABS_W-1:0] wrapped_magnitude(
				logic signed [mid_pkg::POS_W-1:0] a,
				logic signed [mid_pkg::POS_W-1:0] b, logic [mid_pkg::LEN_W-1:0] len);
			logic signed [mid_pkg::WIDE_W-1:0] d;
			logic signed [mid_pkg::WIDE_W-1:0] l;
			logic signed [mid_pkg::WIDE_W-1:0] c;
			d = mid_pkg::WIDE_W'(a) - mid_pkg::WIDE_W'(b);
			l = mid_pkg::WIDE_W'(len);
			if ((d <<< 1) < -l) begin
				c = d + l;
				wraps_up++;
			end else if ((d <<< 1) > l) begin
				c = d - l;
				wraps_down++;
			end else begin
				c = d;
			end
			return mid_pkg::ABS_W'(c[mid_pkg::WIDE_W-1] ? -c : c);
		endfunction

		function logic [mid_pkg::ROOT_W-1:0] min_image_distance(pair_t p);
			logic [mid_pkg::ABS_W-1:0]  mx;
			logic [mid_pkg::ABS_W-1:0]  my;
			logic [mid_pkg::ABS_W-1:0]  mz;
			logic [mid_pkg::SUM_W-1:0]  sum_sq;
			logic [mid_pkg::SUM_W-1:0]  trial_sq;
			logic [mid_pkg::ROOT_W-1:0] root;
			logic [mid_pkg::ROOT_W-1:0] trial;
			mx = wrapped_magnitude(p.first_x, p.second_x, len_x);
			my = wrapped_magnitude(p.first_y, p.second_y, len_y);
			mz = wrapped_magnitude(p.first_z, p.second_z, len_z);
			sum_sq = mid_pkg::SUM_W'(mx) * mid_pkg::SUM_W'(mx)
				+ mid_pkg::SUM_W'(my) * mid_pkg::SUM_W'(my)
				+ mid_pkg::SUM_W'(mz) * mid_pkg::SUM_W'(mz);
			// Q34.32 sum, so the floor root comes out as Q17.16
			root = '0;
			for (int bit_pos = mid_pkg::ROOT_W - 1; bit_pos >= 0; bit_pos--) begin
				trial = root | (mid_pkg::ROOT_W'(1) << bit_pos);
				trial_sq = mid_pkg::SUM_W'(trial) * mid_pkg::SUM_W'(trial);
				if (trial_sq <= sum_sq)
					root = trial;
			end
			return root;
		endfunction

		function void note_pair(pair_t p);
			pending_distances.push_back(min_image_distance(p));
			pairs_seen++;
		endfunction

		function void check_distance(logic [mid_pkg::ROOT_W-1:0] got);
			logic [mid_pkg::ROOT_W-1:0] want;
			distances_checked++;
			if (pending_distances.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: distance %h with no pair outstanding", $time, got);
				return;
			end
			want = pending_distances.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: distance mismatch: expected %h, got %h", $time, want, got);
			end
		endfunction

		function int pending();
			return pending_distances.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mid_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mid_pkg::LEN_W-1:0]     cfg_data;

	mid_pair_if pair ();
	mid_dist_if result ();

	distance_scoreboard sb;
	pair_t              seen_pair;
	int                 tx_gap_pct;
	int                 rx_gap_pct;
	int                 hold_left;
	int                 stall_count;
	int                 cfg_writes;
	bit                 hold_request;

	minimum_image_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pair      (pair),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random back-pressure, plus one long hold on request
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(99) >= rx_gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pair.valid && pair.ready) begin
			seen_pair.first_x  = pair.first_x;
			seen_pair.first_y  = pair.first_y;
			seen_pair.first_z  = pair.first_z;
			seen_pair.second_x = pair.second_x;
			seen_pair.second_y = pair.second_y;
			seen_pair.second_z = pair.second_z;
			sb.note_pair(seen_pair);
		end
		if (arst_n && result.valid && result.ready)
			sb.check_distance(result.distance);
	end

	always @(posedge clk) begin
		if (!arst_n || (pair.valid && pair.ready) || (result.valid && result.ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stall_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// entered at a clock edge; returns at the edge where the word is taken
	task automatic offer_pair(pair_t p);
		while ($urandom_range(99) < tx_gap_pct) begin
			pair.valid <= 1'b0;
			@(posedge clk);
		end
		pair.valid    <= 1'b1;
		pair.first_x  <= p.first_x;
		pair.first_y  <= p.first_y;
		pair.first_z  <= p.first_z;
		pair.second_x <= p.second_x;
		pair.second_y <= p.second_y;
		pair.second_z <= p.second_z;
		do @(posedge clk); while (!pair.ready);
	endtask

	task automatic drain();
		pair.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_length(logic [mid_pkg::CFG_IDX_W-1:0] idx,
			logic [mid_pkg::LEN_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.set_length(idx, value);
		cfg_writes++;
	endtask

	task automatic configure(logic [mid_pkg::LEN_W-1:0] lx, logic [mid_pkg::LEN_W-1:0] ly,
			logic [mid_pkg::LEN_W-1:0] lz);
		write_length(mid_pkg::CFG_LENGTH_X, lx);
		write_length(mid_pkg::CFG_LENGTH_Y, ly);
		write_length(mid_pkg::CFG_LENGTH_Z, lz);
	endtask

	task automatic end_config();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [mid_pkg::LEN_W-1:0] random_length();
		case ($urandom_range(4))
		0: return mid_pkg::LEN_W'($urandom_range(1, 32'h0004_0000));
		1: return mid_pkg::LEN_W'($urandom);
		2: return mid_pkg::LEN_W'($urandom_range(1, 16));
		3: return LEN_MAX;
		default: return '0;
		endcase
	endfunction

	function automatic logic signed [mid_pkg::POS_W-1:0] pick_extreme();
		case ($urandom_range(3))
		0: return POS_MIN;
		1: return POS_MAX;
		2: return '0;
		default: return '1;
		endcase
	endfunction

	// differences uniform up to two boxes or clustered on the half box and one and a half boxes
	function automatic void random_axis(input logic [mid_pkg::LEN_W-1:0] len,
			output logic signed [mid_pkg::POS_W-1:0] a,
			output logic signed [mid_pkg::POS_W-1:0] b);
		longint span;
		longint offset;
		int     kind;
		span = longint'(len);
		kind = $urandom_range(5);
		a = $urandom;
		case (kind)
		0: b = $urandom;
		4: begin
			a = mid_pkg::POS_W'(int'($urandom_range(2 ** 21)) - 2 ** 20);
			b = mid_pkg::POS_W'(int'($urandom_range(2 ** 21)) - 2 ** 20);
		end
		5: begin
			a = pick_extreme();
			b = pick_extreme();
		end
		default: begin
			if (kind == 1)
				offset = longint'($urandom_range(0, 32'(2 * span)));
			else if (kind == 2)
				offset = span / 2 + longint'($urandom_range(2)) - 1;
			else
				offset = span + span / 2 + longint'($urandom_range(2)) - 1;
			if ($urandom_range(1) != 0)
				offset = -offset;
			b = a - mid_pkg::POS_W'(offset);
		end
		endcase
	endfunction

	task automatic run_random(int count);
		pair_t p;
		repeat (count) begin
			random_axis(sb.len_x, p.first_x, p.second_x);
			random_axis(sb.len_y, p.first_y, p.second_y);
			random_axis(sb.len_z, p.first_z, p.second_z);
			offer_pair(p);
		end
		drain();
	endtask

	initial begin
		int half_len;
		sb = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		pair.valid    = 1'b0;
		pair.first_x  = '0;
		pair.first_y  = '0;
		pair.first_z  = '0;
		pair.second_x = '0;
		pair.second_y = '0;
		pair.second_z = '0;
		tx_gap_pct    = 7;
		rx_gap_pct    = 84;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset box of 1.0 on every axis
		offer_pair('{0, 0, 0, 0, 0, 0});
		offer_pair('{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN});
		offer_pair('{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX});
		offer_pair('{32768, 0, 5, 0, 32768, 5});
		offer_pair('{32769, 0, -1, 0, 32769, 32768});
		offer_pair('{98305, -98305, 65536, 0, 0, 0});
		offer_pair('{-1, 0, POS_MIN, 0, -1, 0});
		offer_pair('{-98304, 98304, -65536, 0, 0, 0});
		drain();
		configure(random_length(), random_length(), random_length());
		end_config();
		run_random(RANDOM_ITEMS);

		// zero box: no wrapping at all; the unmapped index must not disturb it
		tx_gap_pct = 84;
		rx_gap_pct = 7;
		configure('0, '0, '0);
		write_length(CFG_UNMAPPED, mid_pkg::LEN_W'($urandom));
		end_config();
		offer_pair('{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN});
		offer_pair('{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX});
		offer_pair('{1, -1, 0, 0, 0, 0});
		drain();
		configure(random_length(), random_length(), random_length());
		end_config();
		run_random(RANDOM_ITEMS);

		// largest box, a box of one LSB, and an even box with exact half-box differences
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		half_len = $urandom_range(1, 2 ** 29);
		configure(LEN_MAX, 1, mid_pkg::LEN_W'(2 * half_len));
		end_config();
		offer_pair('{POS_MAX, 1, half_len, 0, 0, 0});
		offer_pair('{2 ** 30, -1, -half_len, 0, 0, 0});
		offer_pair('{POS_MIN, 0, half_len + 1, 0, 0, 0});
		offer_pair('{-(2 ** 30), 0, -(half_len + 1), 0, 0, 0});
		drain();
		configure(random_length(), random_length(), random_length());
		end_config();
		run_random(RANDOM_ITEMS);

		// output held off while pairs keep coming, so the pipe backs up
		configure(random_length(), random_length(), random_length());
		end_config();
		hold_request = 1'b1;
		run_random(RANDOM_ITEMS);

		repeat (LATENCY + 10) @(posedge clk);
		$display("Run: %0d pairs, %0d distances, %0d register writes over the reset box",
			sb.pairs_seen, sb.distances_checked, cfg_writes);
		$display("and six written ones; %0d +L and %0d -L corrections; one %0d-cycle output hold",
			sb.wraps_up, sb.wraps_down, HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (sb.pending() != 0)
				$display("%0d distances never arrived", sb.pending());
			$display("%0d mismatches", sb.mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
